// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset held off
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset held off
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cbrs_pkg.sv
// ---------------------------------------------------------------------------
// cbrs_pkg
// constants, types and helpers of the cubic bracketing root solver
// ---------------------------------------------------------------------------
package cbrs_pkg;

	// fixed-point format and search limits
	localparam int FRAC_BITS  = 20;
	localparam int MAX_ROUNDS = 64;
	localparam int GW         = 9;                      // guess width
	localparam int XW         = 31;                     // abscissa width
	localparam int FW         = 3 * (XW - 1) - 2 * FRAC_BITS + 2;  // f(x) width
	localparam int SQW        = 2 * XW - FRAC_BITS;     // x^2 width
	localparam int HIW        = XW - FRAC_BITS;         // integer part width
	localparam int QSH        = 30;                     // secant ratio fraction bits
	localparam int QW         = QSH + 1;                // secant ratio width
	localparam int MW         = FW;                     // |f| width
	localparam int DW         = FW + 1;                 // divisor width
	localparam int RW         = $clog2(MAX_ROUNDS + 1);
	localparam int TOLW       = 20;
	localparam int STW        = 2;
	localparam int IDXW       = 1;

	// polynomial coefficients of x^3 - 2x - 5 (the linear one is a shift)
	localparam int F_OFF      = 5;

	// tolerance after reset, about 1e-5
	localparam logic [TOLW-1:0] TOL_RESET = TOLW'(10);

	// result status
	localparam logic [STW-1:0] ST_CONV   = 2'd0;
	localparam logic [STW-1:0] ST_NOSIGN = 2'd1;
	localparam logic [STW-1:0] ST_LIMIT  = 2'd2;

	// register indexes
	localparam logic [IDXW-1:0] REG_METHOD = 1'b0;
	localparam logic [IDXW-1:0] REG_TOL    = 1'b1;

	// evaluator operand select
	localparam logic [1:0] EV_LO  = 2'd0;
	localparam logic [1:0] EV_HI  = 2'd1;
	localparam logic [1:0] EV_EST = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic            load;
		logic            ev_start;
		logic            ev_store;
		logic [1:0]      ev_sel;
		logic            mid;
		logic            div_start;
		logic            sec_mul;
		logic            sec_add;
		logic            narrow;
		logic            emit;
		logic [STW-1:0]  res_status;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic ev_done;
		logic div_done;
		logic method;
		logic no_bracket;
		logic fe_zero;
		logic round_zero;
		logic round_max;
		logic tol_met;
		logic out_free;
	} sts_t;

	// integer guess to fixed point, saturated to the abscissa range
	function automatic logic signed [XW-1:0] to_fixed(input logic signed [GW-1:0] g);
		localparam int VW = GW + FRAC_BITS + XW + 1;
		localparam logic signed [XW-1:0] X_MAX = {1'b0, {(XW - 1){1'b1}}};
		localparam logic signed [XW-1:0] X_MIN = {1'b1, {(XW - 1){1'b0}}};
		logic signed [VW-1:0] v;
		v = VW'(g) <<< FRAC_BITS;
		if (v > VW'(X_MAX))
			return X_MAX;
		else if (v < VW'(X_MIN))
			return X_MIN;
		else
			return XW'(v);
	endfunction

endpackage

// File: hdl/cbrs_feval.sv
// ---------------------------------------------------------------------------
// cbrs_feval
// three-stage evaluator of f(x) = x^3 - 2x - 5 in signed fixed point
// ---------------------------------------------------------------------------
module cbrs_feval (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [cbrs_pkg::XW-1:0]   x,
	output logic                             done,
	output logic signed [cbrs_pkg::FW-1:0]   f
);

	localparam int XW   = cbrs_pkg::XW;
	localparam int FB   = cbrs_pkg::FRAC_BITS;
	localparam int SQW  = cbrs_pkg::SQW;
	localparam int HIW  = cbrs_pkg::HIW;
	localparam int FW   = cbrs_pkg::FW;
	localparam int CXW  = SQW + HIW + 2;

	logic                  v_s1, v_s2, v_s3;
	logic [XW-1:0]         ax;
	logic [2*XW-1:0]       sq_full;
	logic [SQW-1:0]        sq_s1;
	logic [XW-1:0]         ax_s1;
	logic                  neg_s1, neg_s2;
	logic signed [XW-1:0]  x_s1, x_s2;
	logic [SQW+HIW-1:0]    ph_w, ph_s2;
	logic [SQW+FB-1:0]     pl_w;
	logic [SQW-1:0]        pl_s2;
	logic [SQW+HIW:0]      cube;
	logic signed [CXW-1:0] cube_s, f_w;
	logic signed [FW-1:0]  f_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: magnitude squared, truncated
	assign ax      = x[XW-1] ? XW'(~x + 1'b1) : XW'(x);
	assign sq_full = ax * ax;

	always_ff @(posedge clk) begin
		sq_s1  <= sq_full[2*XW-1:FB];
		ax_s1  <= ax;
		neg_s1 <= x[XW-1];
		x_s1   <= x;
	end

	// stage 2: x^2 times integer and fraction parts of |x|
	assign ph_w = sq_s1 * ax_s1[XW-1:FB];
	assign pl_w = sq_s1 * ax_s1[FB-1:0];

	always_ff @(posedge clk) begin
		ph_s2  <= ph_w;
		pl_s2  <= pl_w[SQW+FB-1:FB];
		neg_s2 <= neg_s1;
		x_s2   <= x_s1;
	end

	// stage 3: signed cube minus linear and constant terms
	// |x| < 2^(XW-1) keeps the cube far below any saturation point
	assign cube   = {1'b0, ph_s2} + (SQW + HIW + 1)'(pl_s2);
	assign cube_s = neg_s2 ? -$signed({1'b0, cube}) : $signed({1'b0, cube});
	assign f_w    = cube_s - (CXW'(x_s2) <<< 1) - (CXW'(cbrs_pkg::F_OFF) <<< FB);

	always_ff @(posedge clk) begin
		f_s3 <= f_w[FW-1:0];
	end

	assign done = v_s3;
	assign f    = f_s3;

endmodule

// File: hdl/cbrs_div.sv
// ---------------------------------------------------------------------------
// cbrs_div
// restoring divider, one quotient bit a cycle, gives floor(num * 2^QSH / den)
// ---------------------------------------------------------------------------
module cbrs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbrs_pkg::MW-1:0]    num,
	input  logic [cbrs_pkg::DW-1:0]    den,
	output logic                       done,
	output logic [cbrs_pkg::QW-1:0]    quo
);

	localparam int DW   = cbrs_pkg::DW;
	localparam int QW   = cbrs_pkg::QW;
	localparam int CNTW = $clog2(QW + 1);

	logic            busy_q, done_q, first_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   r_q, d_q;
	logic [QW-1:0]   q_q;
	logic [DW:0]     t;
	logic            ge;

	// trial remainder: first step compares the numerator as is
	assign t  = first_q ? {1'b0, r_q} : {r_q, 1'b0};
	assign ge = t >= {1'b0, d_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= CNTW'(QW);
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= DW'(num);
			d_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? DW'(t - {1'b0, d_q}) : DW'(t);
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// File: hdl/cbrs_dp.sv
// ---------------------------------------------------------------------------
// cbrs_dp
// datapath: bracket registers, evaluator, secant divider, result register
// ---------------------------------------------------------------------------
module cbrs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cbrs_pkg::cmd_t                   cmd,
	output cbrs_pkg::sts_t                   sts,
	input  logic signed [cbrs_pkg::GW-1:0]   left_guess,
	input  logic signed [cbrs_pkg::GW-1:0]   right_guess,
	input  logic                             cfg_we,
	input  logic [cbrs_pkg::IDXW-1:0]        cfg_index,
	input  logic [cbrs_pkg::TOLW-1:0]        cfg_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [cbrs_pkg::XW-1:0]   root,
	output logic [cbrs_pkg::STW-1:0]         status,
	output logic [cbrs_pkg::RW-1:0]          iterations
);

	localparam int XW  = cbrs_pkg::XW;
	localparam int FW  = cbrs_pkg::FW;
	localparam int MW  = cbrs_pkg::MW;
	localparam int DW  = cbrs_pkg::DW;
	localparam int QW  = cbrs_pkg::QW;
	localparam int RW  = cbrs_pkg::RW;
	localparam int PW  = XW + 1 + QW + 1;

	logic                        method_q;
	logic [cbrs_pkg::TOLW-1:0]   tol_q;
	logic signed [XW-1:0]        low_q, high_q, est_q, prev_q, ev_x;
	logic signed [FW-1:0]        fl_q, fh_q, fe_q, ev_f;
	logic [RW-1:0]               round_q;
	logic                        ev_done, div_done, dz_q;
	logic [MW-1:0]               ma, mb;
	logic [DW-1:0]               den;
	logic [QW-1:0]               quo;
	logic signed [XW:0]          sum_w, span_w, diff_w;
	logic [XW:0]                 dmag;
	logic signed [PW-1:0]        prod_q, sec_w;
	logic                        move_high;
	logic                        oval_q;
	logic signed [XW-1:0]        oroot_q;
	logic [cbrs_pkg::STW-1:0]    ostat_q;
	logic [RW-1:0]               oiter_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= 1'b0;
			tol_q    <= cbrs_pkg::TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cbrs_pkg::REG_METHOD: method_q <= cfg_data[0];
				cbrs_pkg::REG_TOL:    tol_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// evaluator operand select
	always_comb begin
		case (cmd.ev_sel)
			cbrs_pkg::EV_LO: ev_x = low_q;
			cbrs_pkg::EV_HI: ev_x = high_q;
			default:         ev_x = est_q;
		endcase
	end

	cbrs_feval u_feval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ev_start),
		.x      (ev_x),
		.done   (ev_done),
		.f      (ev_f)
	);

	// secant ratio |f(lo)| / (|f(lo)| + |f(hi)|)
	assign ma  = fl_q[FW-1] ? MW'(-fl_q) : MW'(fl_q);
	assign mb  = fh_q[FW-1] ? MW'(-fh_q) : MW'(fh_q);
	assign den = DW'(ma) + DW'(mb);

	cbrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (ma),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// midpoint, secant step and estimate change
	assign sum_w     = (XW + 1)'(low_q) + (XW + 1)'(high_q);
	assign span_w    = (XW + 1)'(high_q) - (XW + 1)'(low_q);
	assign sec_w     = PW'(low_q) + (prod_q >>> cbrs_pkg::QSH);
	assign diff_w    = (XW + 1)'(prev_q) - (XW + 1)'(est_q);
	assign dmag      = diff_w[XW] ? (XW + 1)'(-diff_w) : (XW + 1)'(diff_w);
	assign move_high = (fl_q != '0) && (fe_q[FW-1] != fl_q[FW-1]);

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_q <= '0;
		else if (cmd.load)
			round_q <= '0;
		else if (cmd.narrow)
			round_q <= round_q + 1'b1;
	end

	// bracket, estimate and function values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			low_q  <= cbrs_pkg::to_fixed(left_guess);
			high_q <= cbrs_pkg::to_fixed(right_guess);
			est_q  <= '0;
			prev_q <= '0;
		end
		if (cmd.ev_store && ev_done) begin
			case (cmd.ev_sel)
				cbrs_pkg::EV_LO: fl_q <= ev_f;
				cbrs_pkg::EV_HI: fh_q <= ev_f;
				default:         fe_q <= ev_f;
			endcase
		end
		if (cmd.div_start)
			dz_q <= (den == '0);
		if (cmd.mid)
			est_q <= sum_w[XW:1];
		if (cmd.sec_mul)
			prod_q <= span_w * $signed({1'b0, quo});
		if (cmd.sec_add)
			est_q <= dz_q ? low_q : sec_w[XW-1:0];
		if (cmd.narrow) begin
			prev_q <= est_q;
			if (move_high) begin
				high_q <= est_q;
				fh_q   <= fe_q;
			end else begin
				low_q <= est_q;
				fl_q  <= fe_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			oval_q <= 1'b0;
		else if (cmd.emit)
			oval_q <= 1'b1;
		else if (out_ready)
			oval_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			oroot_q <= est_q;
			ostat_q <= cmd.res_status;
			oiter_q <= round_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.ev_done    = ev_done;
		sts.div_done   = div_done;
		sts.method     = method_q;
		sts.no_bracket = ((fl_q != '0) && (fh_q != '0) && (fl_q[FW-1] == fh_q[FW-1]))
			|| (method_q && (fl_q == fh_q));
		sts.fe_zero    = (fe_q == '0);
		sts.round_zero = (round_q == '0);
		sts.round_max  = (round_q >= RW'(cbrs_pkg::MAX_ROUNDS));
		sts.tol_met    = dmag < (XW + 1)'(tol_q);
		sts.out_free   = !oval_q || out_ready;
	end

	assign out_valid  = oval_q;
	assign root       = oroot_q;
	assign status     = ostat_q;
	assign iterations = oiter_q;

endmodule

// File: hdl/cbrs_ctrl.sv
// ---------------------------------------------------------------------------
// cbrs_ctrl
// search sequencer: evaluates the ends, steps the bracket, hands off results
// ---------------------------------------------------------------------------
module cbrs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cbrs_pkg::sts_t  sts,
	output cbrs_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EV_LO   = 4'd1;
	localparam logic [3:0] S_W_LO    = 4'd2;
	localparam logic [3:0] S_EV_HI   = 4'd3;
	localparam logic [3:0] S_W_HI    = 4'd4;
	localparam logic [3:0] S_CHECK   = 4'd5;
	localparam logic [3:0] S_NEXT    = 4'd6;
	localparam logic [3:0] S_DIV_W   = 4'd7;
	localparam logic [3:0] S_SEC_MUL = 4'd8;
	localparam logic [3:0] S_SEC_ADD = 4'd9;
	localparam logic [3:0] S_POST    = 4'd10;
	localparam logic [3:0] S_EV_E    = 4'd11;
	localparam logic [3:0] S_W_E     = 4'd12;
	localparam logic [3:0] S_TEST    = 4'd13;
	localparam logic [3:0] S_NARROW  = 4'd14;
	localparam logic [3:0] S_FIN     = 4'd15;

	logic [3:0]                 state_q, state_d;
	logic [cbrs_pkg::STW-1:0]   stat_q, stat_d;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		stat_d         = stat_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.res_status = stat_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EV_LO;
				end
			end
			S_EV_LO: begin
				cmd.ev_sel   = cbrs_pkg::EV_LO;
				cmd.ev_start = 1'b1;
				state_d      = S_W_LO;
			end
			S_W_LO: begin
				cmd.ev_sel   = cbrs_pkg::EV_LO;
				cmd.ev_store = 1'b1;
				if (sts.ev_done)
					state_d = S_EV_HI;
			end
			S_EV_HI: begin
				cmd.ev_sel   = cbrs_pkg::EV_HI;
				cmd.ev_start = 1'b1;
				state_d      = S_W_HI;
			end
			S_W_HI: begin
				cmd.ev_sel   = cbrs_pkg::EV_HI;
				cmd.ev_store = 1'b1;
				if (sts.ev_done)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.no_bracket) begin
					stat_d  = cbrs_pkg::ST_NOSIGN;
					state_d = S_FIN;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (sts.method) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV_W;
				end else begin
					cmd.mid = 1'b1;
					state_d = S_POST;
				end
			end
			S_DIV_W: begin
				if (sts.div_done)
					state_d = S_SEC_MUL;
			end
			S_SEC_MUL: begin
				cmd.sec_mul = 1'b1;
				state_d     = S_SEC_ADD;
			end
			S_SEC_ADD: begin
				cmd.sec_add = 1'b1;
				state_d     = S_POST;
			end
			// first estimate skips the convergence test
			S_POST: begin
				if (!sts.round_zero && sts.tol_met) begin
					stat_d  = cbrs_pkg::ST_CONV;
					state_d = S_FIN;
				end else begin
					state_d = S_EV_E;
				end
			end
			S_EV_E: begin
				cmd.ev_sel   = cbrs_pkg::EV_EST;
				cmd.ev_start = 1'b1;
				state_d      = S_W_E;
			end
			S_W_E: begin
				cmd.ev_sel   = cbrs_pkg::EV_EST;
				cmd.ev_store = 1'b1;
				if (sts.ev_done)
					state_d = S_TEST;
			end
			S_TEST: begin
				if (sts.fe_zero) begin
					stat_d  = cbrs_pkg::ST_CONV;
					state_d = S_FIN;
				end else if (sts.round_max) begin
					stat_d  = cbrs_pkg::ST_LIMIT;
					state_d = S_FIN;
				end else begin
					state_d = S_NARROW;
				end
			end
			S_NARROW: begin
				cmd.narrow = 1'b1;
				state_d    = S_NEXT;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= cbrs_pkg::ST_CONV;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

endmodule

// File: hdl/cubic_bracketing_root_solver_core.sv
// ---------------------------------------------------------------------------
// cubic_bracketing_root_solver_core
// bracketing root search of x^3 - 2x - 5 by bisection or false position
// ---------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tdata: left_guess, right_guess
// m_       | out       | m_tvalid/m_tready  | m_tdata: root, iterations; m_tuser: status
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (0 method, 1 tolerance)
//
// one word at a time; both ends are evaluated first, then each round runs the
// 3-stage cubic evaluator, and in false position also the restoring divider
// that forms the secant ratio; up to 64 rounds
// a new word is taken while the previous result waits in the output register
// reset is asynchronous and clears the sequencer, valids and config registers
// ---------------------------------------------------------------------------
module cubic_bracketing_root_solver_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,    // left_guess, right_guess, zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,    // root, iterations, zero pad
	output logic [cbrs_pkg::STW-1:0]         m_tuser,    // status
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbrs_pkg::IDXW-1:0]        cfg_index,
	input  logic [cbrs_pkg::TOLW-1:0]        cfg_data
);

	localparam int GW = cbrs_pkg::GW;

	cbrs_pkg::cmd_t                  cmd;
	cbrs_pkg::sts_t                  sts;
	logic signed [GW-1:0]            left_guess, right_guess;
	logic signed [cbrs_pkg::XW-1:0]  root;
	logic [cbrs_pkg::RW-1:0]         iterations;

	// input word unpack
	assign left_guess  = s_tdata[GW-1:0];
	assign right_guess = s_tdata[2*GW-1:GW];
	assign cfg_ready   = 1'b1;

	cbrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbrs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.left_guess  (left_guess),
		.right_guess (right_guess),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.root        (root),
		.status      (m_tuser),
		.iterations  (iterations)
	);

	// output word pack
	assign m_tdata = {2'b00, iterations, root};

endmodule

// File: hdl/cbrs_checker.sv
// ---------------------------------------------------------------------------
// cbrs_checker
// port-level checks of the root solver result channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbrs_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [39:0]                 m_tdata,
	input  logic [cbrs_pkg::STW-1:0]    m_tuser
);

	logic [cbrs_pkg::RW-1:0] iter;
	logic [cbrs_pkg::XW-1:0] root;

	assign root = m_tdata[30:0];
	assign iter = m_tdata[37:31];

	// stalled word holds
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// no bracket reports zero root and no rounds
	`ASSERT_IMPL(a_nosign, clk, arst_n, m_tvalid && (m_tuser == cbrs_pkg::ST_NOSIGN), (root == '0) && (iter == '0), "no-bracket result not zero")

	// round cap reports the full count
	`ASSERT_IMPL(a_limit, clk, arst_n, m_tvalid && (m_tuser == cbrs_pkg::ST_LIMIT), iter == cbrs_pkg::RW'(cbrs_pkg::MAX_ROUNDS), "limit result with short count")

	// round count never passes the cap
	`ASSERT_IMPL(a_iter, clk, arst_n, m_tvalid, iter <= cbrs_pkg::RW'(cbrs_pkg::MAX_ROUNDS), "round count above cap")

endmodule

bind cubic_bracketing_root_solver_core cbrs_checker u_cbrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: sim/cubic_bracketing_root_solver_core_test.sv
// ---------------------------------------------------------------------------
// cubic_bracketing_root_solver_core_test
// checks the bracketing root search against a bit-exact software predictor:
// directed brackets and extremes under both methods, then random brackets
// and noise over several method and tolerance settings, with random idle
// and stall bursts on both stream sides
// ---------------------------------------------------------------------------
module cubic_bracketing_root_solver_core_test;

	localparam int GW         = cbrs_pkg::GW;
	localparam int XW         = cbrs_pkg::XW;
	localparam int STW        = cbrs_pkg::STW;
	localparam int RW         = cbrs_pkg::RW;
	localparam int IDXW       = cbrs_pkg::IDXW;
	localparam int TOLW       = cbrs_pkg::TOLW;
	localparam int FRAC_BITS  = cbrs_pkg::FRAC_BITS;
	localparam int QSH        = cbrs_pkg::QSH;
	localparam int MAX_ROUNDS = cbrs_pkg::MAX_ROUNDS;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [GW-1:0] right;
		logic signed [GW-1:0] left;
	} guess_pair_t;

	typedef struct packed {
		logic signed [XW-1:0] root;
		logic [STW-1:0]       status;
		logic [RW-1:0]        rounds;
	} root_result_t;

	localparam u64_t CUBE_CAP  = u64_t'(1) << 61;
	localparam u64_t FRAC_MASK = (u64_t'(1) << FRAC_BITS) - 1;
	localparam int   RANDOM_PHASES = 8;
	localparam int   PHASE_WORDS   = 56;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;
	logic [STW-1:0]        m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDXW-1:0]       cfg_index = '0;
	logic [TOLW-1:0]       cfg_data = '0;

	// mirror of the configuration registers
	logic                  method_setting = 1'b0;
	logic [TOLW-1:0]       tol_setting = cbrs_pkg::TOL_RESET;

	guess_pair_t           pending_guesses[$];
	root_result_t          expected_roots[$];
	guess_pair_t           offered;
	root_result_t          got;
	logic                  calm = 1'b0;
	logic                  hold_word;
	int                    send_gap = 0;
	int                    stall_left = 0;
	int                    error_count = 0;
	int                    words_sent = 0;
	int                    roots_seen = 0;
	int                    status_seen[3] = '{0, 0, 0};

	cubic_bracketing_root_solver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// f(x) = x^3 - 2x - 5 with a saturated cube magnitude
	function automatic longint cubic_value(input longint x);
		u64_t ax, sq, whole, part, cube, p2;
		longint c;
		ax = (x < 0) ? u64_t'(-x) : u64_t'(x);
		sq = (ax * ax) >> FRAC_BITS;
		whole = ax >> FRAC_BITS;
		part = ax & FRAC_MASK;
		if (whole != 0 && sq > CUBE_CAP / whole) begin
			cube = CUBE_CAP;
		end else begin
			p2 = (sq * part) >> FRAC_BITS;
			cube = sq * whole;
			cube = (cube > CUBE_CAP - p2) ? CUBE_CAP : cube + p2;
		end
		c = (x < 0) ? -longint'(cube) : longint'(cube);
		return c - 2 * x - (longint'(cbrs_pkg::F_OFF) <<< FRAC_BITS);
	endfunction

	function automatic int sign_of(input longint v);
		if (v > 0)
			return 1;
		else if (v < 0)
			return -1;
		return 0;
	endfunction

	// midpoint, or secant point from a restoring division of |f(a)| by |f(a)|+|f(b)|
	function automatic longint next_point(input longint a, input longint b);
		longint fa, fb;
		u64_t ma, mb, d, r, q;
		if (!method_setting)
			return (a + b) >>> 1;
		fa = cubic_value(a);
		fb = cubic_value(b);
		ma = (fa < 0) ? u64_t'(-fa) : u64_t'(fa);
		mb = (fb < 0) ? u64_t'(-fb) : u64_t'(fb);
		d = ma + mb;
		if (d == 0)
			return a;
		r = ma;
		q = 0;
		if (r >= d) begin
			q = 1;
			r = r - d;
		end
		for (int i = 0; i < QSH; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		return a + (((b - a) * longint'(q)) >>> QSH);
	endfunction

	// full search for one pair of guesses
	function automatic root_result_t solve_cubic(input guess_pair_t g);
		longint lo, hi, est, prev, fl, fr, fe, diff;
		int rounds;
		logic done;
		root_result_t res;
		lo = longint'(g.left) <<< FRAC_BITS;
		hi = longint'(g.right) <<< FRAC_BITS;
		rounds = 0;
		fl = cubic_value(lo);
		fr = cubic_value(hi);
		if (sign_of(fl) * sign_of(fr) > 0 || (method_setting && fl == fr)) begin
			est = 0;
			res.status = cbrs_pkg::ST_NOSIGN;
		end else begin
			est = next_point(lo, hi);
			done = 1'b0;
			while (!done) begin
				fe = cubic_value(est);
				if (fe == 0) begin
					res.status = cbrs_pkg::ST_CONV;
					done = 1'b1;
				end else if (rounds >= MAX_ROUNDS) begin
					res.status = cbrs_pkg::ST_LIMIT;
					done = 1'b1;
				end else begin
					prev = est;
					if (sign_of(fe) * sign_of(cubic_value(lo)) < 0)
						hi = est;
					else
						lo = est;
					est = next_point(lo, hi);
					rounds++;
					diff = prev - est;
					if (diff < 0)
						diff = -diff;
					if (diff < longint'(tol_setting)) begin
						res.status = cbrs_pkg::ST_CONV;
						done = 1'b1;
					end
				end
			end
		end
		res.root = XW'(est);
		res.rounds = RW'(rounds);
		return res;
	endfunction

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50000000;
		$display("CHECK FAILED");
		$finish;
	end

	// guess word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			hold_word = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				expected_roots.push_back(solve_cubic(offered));
				words_sent++;
				if (!calm && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 9);
			end
			if (!hold_word) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_guesses.size() != 0) begin
					offered = pending_guesses.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, offered.right, offered.left};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result word monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.root = m_tdata[XW-1:0];
				got.rounds = m_tdata[XW+RW-1:XW];
				got.status = m_tuser;
				roots_seen++;
				if (got.status < 3)
					status_seen[got.status]++;
				if (expected_roots.size() == 0) begin
					$error("result word with no expected root: root %0d status %0d",
						got.root, got.status);
					error_count++;
				end else begin
					root_result_t want;
					want = expected_roots.pop_front();
					if (got.root !== want.root) begin
						$error("root: expected %0d, got %0d", want.root, got.root);
						error_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_count++;
					end
					if (got.rounds !== want.rounds) begin
						$error("iterations: expected %0d, got %0d", want.rounds, got.rounds);
						error_count++;
					end
				end
			end
			// random stall bursts
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// wait until every word is through and every root has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_guesses.size() != 0 || s_tvalid || expected_roots.size() != 0);
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	// one register write, entered at a rising edge
	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [TOLW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == cbrs_pkg::REG_METHOD)
			method_setting = value[0];
		else
			tol_setting = value;
		@(posedge clk);
	endtask

	// directed brackets: normal, reversed, extremes, equal ends, no sign change
	task automatic push_directed();
		int pairs[12][2] = '{
			'{2, 3}, '{3, 2}, '{-256, 255}, '{255, -256}, '{-256, -256}, '{255, 255},
			'{0, 0}, '{2, 2}, '{-1, 3}, '{1, 255}, '{-256, 3}, '{2, -1}
		};
		guess_pair_t g;
		foreach (pairs[i]) begin
			g.left = GW'(pairs[i][0]);
			g.right = GW'(pairs[i][1]);
			pending_guesses.push_back(g);
		end
	endtask

	// stimulus sequence
	initial begin
		logic          phase_method[RANDOM_PHASES];
		int            phase_tol[RANDOM_PHASES];
		guess_pair_t   g;
		int            a, b, pick, t;

		phase_method = '{0, 1, 0, 1, 1, 0, 1, 0};
		phase_tol = '{1, 1, 1048575, 1048575, 0, 0, 10, 10};
		phase_tol[4] = $urandom_range(1, 1048575);
		phase_tol[5] = $urandom_range(1, 4096);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: bisection, default tolerance
		push_directed();
		wait_idle();

		// same brackets by false position
		write_reg(cbrs_pkg::REG_METHOD, (TOLW'($urandom) & ~TOLW'(1)) | TOLW'(1));
		write_reg(cbrs_pkg::REG_TOL, cbrs_pkg::TOL_RESET);
		push_directed();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			if (p == RANDOM_PHASES - 1)
				calm = 1'b1;
			write_reg(cbrs_pkg::REG_METHOD,
				(TOLW'($urandom) & ~TOLW'(1)) | TOLW'(phase_method[p]));
			write_reg(cbrs_pkg::REG_TOL, TOLW'(phase_tol[p]));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					// narrow bracket around the root
					a = $urandom_range(0, 6) - 4;
					b = $urandom_range(3, 8);
				end else if (pick < 6) begin
					// wide bracket
					a = $urandom_range(0, 258) - 256;
					b = $urandom_range(3, 255);
				end else begin
					// noise over the whole range
					a = $urandom_range(0, 511) - 256;
					b = $urandom_range(0, 511) - 256;
				end
				if (pick < 6 && $urandom_range(0, 1) == 1) begin
					t = a;
					a = b;
					b = t;
				end
				g.left = GW'(a);
				g.right = GW'(b);
				pending_guesses.push_back(g);
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (expected_roots.size() != 0) begin
			$error("%0d expected roots never arrived", expected_roots.size());
			error_count++;
		end
		$display("searched %0d guess pairs under both methods and %0d settings", words_sent,
			RANDOM_PHASES + 2);
		$display("results: %0d converged, %0d without sign change, %0d at round cap",
			status_seen[cbrs_pkg::ST_CONV], status_seen[cbrs_pkg::ST_NOSIGN],
			status_seen[cbrs_pkg::ST_LIMIT]);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
